### rtl/core/dq_pkg.sv
`default_nettype none
package dq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_QUERY      = 3'd5
  } dq_action_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } dq_status_e;

  // the operation that every cell performs, shared by all cells
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_RIGHT,
    OP_SHIFT_LEFT,
    OP_WRITE_BACK,
    OP_DROP_BACK,
    OP_CLEAR
  } dq_op_e;

  typedef struct packed {
    dq_op_e                    op;
    logic signed [DATA_W-1:0]  value;
  } dq_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/dq_cell.sv
`default_nettype none
module dq_cell
  import dq_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire dq_ctrl_t                 ctrl_i,
  input  wire logic signed [DATA_W-1:0] left_val_i,
  input  wire logic                     left_occ_i,
  input  wire logic signed [DATA_W-1:0] right_val_i,
  input  wire logic                     right_occ_i,
  output logic signed [DATA_W-1:0]      val_o,
  output logic                          occ_o,
  output logic                          last_o
);

  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     occ_q, occ_d;

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    case (ctrl_i.op)
      OP_SHIFT_RIGHT: begin
        val_d = left_val_i;
        occ_d = left_occ_i;
      end
      OP_SHIFT_LEFT: begin
        val_d = right_val_i;
        occ_d = right_occ_i;
      end
      OP_WRITE_BACK: begin
        // first free slot takes the beat
        if (!occ_q && left_occ_i) begin
          val_d = ctrl_i.value;
          occ_d = 1'b1;
        end
      end
      OP_DROP_BACK: begin
        if (occ_q && !right_occ_i) occ_d = 1'b0;
      end
      OP_CLEAR: occ_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o  = val_q;
  assign occ_o  = occ_q;
  assign last_o = occ_q && !right_occ_i;

endmodule
`default_nettype wire

### rtl/core/double_ended_queue.sv
`default_nettype none
// Double-ended queue built as a row of shifting cells; front sits in cell 0.
// The result beat is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the output side keeps taking beats;
//   on a front push or pop each cell moves one step toward its neighbor.
// Reset: asynchronous, active low; queue empty, no result pending, no
//   clearing pass needed.
module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [2:0]               action_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      front_value_o,
  output logic signed [DATA_W-1:0]      back_value_o,
  output logic [CNT_W-1:0]              count_o,
  output logic                          is_empty_o,
  output logic [1:0]                    status_o
);

  logic                     accept;
  logic                     full, empty;
  logic                     out_valid_q;
  dq_status_e               status_q, status_d;
  logic [CNT_W-1:0]         count_q, count_d;
  dq_ctrl_t                 ctrl;

  logic signed [DATA_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]         cell_occ;
  logic [DEPTH-1:0]         cell_last;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.value = value_i;
    status_d   = ST_DONE;
    count_d    = count_q;
    case (action_i)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          ctrl.op = (action_i == ACT_PUSH_FRONT) ? OP_SHIFT_RIGHT : OP_WRITE_BACK;
          count_d = count_q + 1'b1;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          ctrl.op = (action_i == ACT_POP_FRONT) ? OP_SHIFT_LEFT : OP_DROP_BACK;
          count_d = count_q - 1'b1;
        end
      end
      ACT_CLEAR: begin
        ctrl.op = OP_CLEAR;
        count_d = '0;
      end
      default: ;
    endcase
    if (!accept) ctrl.op = OP_HOLD;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] lv, rv;
    logic                     lo, ro;
    if (i == 0) begin : g_head
      assign lv = value_i;
      assign lo = 1'b1;
    end else begin : g_mid_l
      assign lv = cell_val[i-1];
      assign lo = cell_occ[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_mid_r
      assign rv = cell_val[i+1];
      assign ro = cell_occ[i+1];
    end
    dq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_val_i  (lv),
      .left_occ_i  (lo),
      .right_val_i (rv),
      .right_occ_i (ro),
      .val_o       (cell_val[i]),
      .occ_o       (cell_occ[i]),
      .last_o      (cell_last[i])
    );
  end

  // exactly one cell flags itself as back when non-empty
  always_comb begin
    back_value_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_last[i]) back_value_o = back_value_o | cell_val[i];
    end
  end

  assign front_value_o = cell_occ[0] ? cell_val[0] : '0;
  assign count_o       = count_q;
  assign is_empty_o    = empty;
  assign status_o      = status_q;
  assign out_valid_o   = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      status_q    <= ST_DONE;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
        status_q    <= status_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### verif/double_ended_queue_test.sv
module double_ended_queue_test;
  import dq_pkg::*;

  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 200;

  typedef struct {
    logic [2:0]               act;
    logic signed [DATA_W-1:0] val;
  } deque_cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    logic [CNT_W-1:0]         fill;
    logic                     empty;
    logic [1:0]               status;
  } deque_view_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [2:0]               action_i = ACT_QUERY;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] front_value_o;
  logic signed [DATA_W-1:0] back_value_o;
  logic [CNT_W-1:0]         count_o;
  logic                     is_empty_o;
  logic [1:0]               status_o;

  deque_cmd_t  cmd_q[$];
  deque_view_t deque_views[$];

  // predicted deque contents
  logic signed [DATA_W-1:0] ring_mem[DEPTH];
  int unsigned              ring_head = 0;
  int unsigned              ring_fill = 0;

  int unsigned err_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  int unsigned beats_taken = 0;
  int unsigned idle_cycles = 0;
  logic [31:0] cycle_no = '0;

  double_ended_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .count_o       (count_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic deque_view_t apply_action(logic [2:0] act, logic signed [DATA_W-1:0] val);
    deque_view_t v;
    v.status = ST_DONE;
    case (act)
      ACT_PUSH_FRONT: begin
        if (ring_fill == DEPTH) begin
          v.status = ST_OVERFLOW;
        end else begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_mem[ring_head] = val;
          ring_fill++;
        end
      end
      ACT_PUSH_BACK: begin
        if (ring_fill == DEPTH) begin
          v.status = ST_OVERFLOW;
        end else begin
          ring_mem[(ring_head + ring_fill) % DEPTH] = val;
          ring_fill++;
        end
      end
      ACT_POP_FRONT: begin
        if (ring_fill == 0) begin
          v.status = ST_UNDERFLOW;
        end else begin
          ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
        end
      end
      ACT_POP_BACK: begin
        if (ring_fill == 0) v.status = ST_UNDERFLOW;
        else ring_fill--;
      end
      ACT_CLEAR: begin
        ring_fill = 0;
        ring_head = 0;
      end
      default: ;  // query and the spare codes leave the state alone
    endcase
    v.front = '0;
    v.back = '0;
    if (ring_fill != 0) begin
      v.front = ring_mem[ring_head];
      v.back = ring_mem[(ring_head + ring_fill - 1) % DEPTH];
    end
    v.fill = ring_fill[CNT_W-1:0];
    v.empty = (ring_fill == 0);
    return v;
  endfunction

  // mostly short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_action(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return ACT_CLEAR;
    if (r < 6) return ACT_QUERY;
    if (r < 8) return $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  task automatic queue_cmd(logic [2:0] act, logic signed [DATA_W-1:0] val);
    deque_cmd_t c;
    c.act = act;
    c.val = val;
    cmd_q.push_back(c);
  endtask

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
    err_cnt++;
  endtask

  // driver: offers commands from cmd_q with random gaps
  always @(posedge clk_i) begin
    deque_cmd_t c;
    logic offer;
    offer = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        offer = 1'b0;
        if (!cycle_no[8] && $urandom_range(0, 99) < 35) send_gap = gap_len();
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_q.size() != 0) begin
          c = cmd_q.pop_front();
          action_i <= c.act;
          value_i <= c.val;
          offer = 1'b1;
        end
      end
      in_valid_i <= offer;
    end
  end

  // monitor: predicts on each input beat, checks each output beat, drives ready
  always @(posedge clk_i) begin
    deque_view_t want;
    logic ready;
    ready = out_ready_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) deque_views.push_back(apply_action(action_i, value_i));
      if (out_valid_o && out_ready_i) begin
        beats_taken++;
        if (deque_views.size() == 0) begin
          report_mismatch("beat with nothing pending", count_o, '0);
        end else begin
          want = deque_views.pop_front();
          if (front_value_o !== want.front) report_mismatch("front", front_value_o, want.front);
          if (back_value_o !== want.back) report_mismatch("back", back_value_o, want.back);
          if (count_o !== want.fill) report_mismatch("count", count_o, want.fill);
          if (is_empty_o !== want.empty) report_mismatch("is_empty", is_empty_o, want.empty);
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        end
        // long back-pressure so the input side stalls
        if (beats_taken == 150 || beats_taken == 900) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else if (cycle_no[9] || $urandom_range(0, 99) < 70) begin
        ready = 1'b1;
      end else begin
        hold_left = gap_len() - 1;
        ready = 1'b0;
      end
      out_ready_i <= ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned burst;
    int unsigned push_pct;
    int unsigned r;

    // empty ring: query, underflow both ends, spare codes, then a push and a pop at each end
    queue_cmd(ACT_QUERY, 32'sh5a5a_a5a5);
    queue_cmd(ACT_POP_FRONT, '0);
    queue_cmd(ACT_POP_BACK, -32'sd1);
    queue_cmd(ACT_SPARE_6, 32'sh7fff_ffff);
    queue_cmd(ACT_SPARE_7, 32'sh8000_0000);
    queue_cmd(ACT_PUSH_FRONT, 32'sh7fff_ffff);
    queue_cmd(ACT_PUSH_BACK, 32'sh8000_0000);
    queue_cmd(ACT_POP_FRONT, '0);
    queue_cmd(ACT_POP_BACK, '0);
    // fill to the brim from both ends, head wraps right away
    for (int i = 0; i < DEPTH; i++) begin
      queue_cmd((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, (i == 3) ? -32'sd1 : (i == 4) ? '0 :
                $urandom);
    end
    queue_cmd(ACT_PUSH_FRONT, 32'sh1234_5678);
    queue_cmd(ACT_PUSH_BACK, 32'sh8765_4321);
    queue_cmd(ACT_CLEAR, '0);
    queue_cmd(ACT_CLEAR, $urandom);

    // random bursts leaning toward fill, drain or neither
    while (cmd_q.size() < RANDOM_ITEMS + 30) begin
      burst = $urandom_range(4, 40);
      r = $urandom_range(0, 99);
      push_pct = (r < 35) ? 80 : (r < 70) ? 20 : 50;
      repeat (burst) queue_cmd(rand_action(push_pct), rand_value());
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (cmd_q.size() != 0 || in_valid_i || deque_views.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
